FILE: hw/rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg - shared types and constants of the stop-and-wait receiver
// Header and reply layouts, reply flag codes, outcome codes and the 16-bit
// ones-complement fold used by the reply checksum.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam int unsigned HalfWidth    = 16;
   localparam int unsigned ReqDataWidth = 176;
   localparam int unsigned RspDataWidth = 48;

   // reply flag codes: in-use plus ACK, in-use plus NACK
   localparam logic [6:0] FlagInUse    = 7'd1;
   localparam logic [6:0] FlagAckBit   = 7'd4;
   localparam logic [6:0] FlagNackBit  = 7'd64;
   localparam logic [6:0] ReplyAckCode  = FlagInUse | FlagAckBit;
   localparam logic [6:0] ReplyNackCode = FlagInUse | FlagNackBit;

   localparam logic [HalfWidth-1:0] HalfOnes = 16'hffff;

   typedef enum logic [1:0] {
      OUTCOME_DUPLICATE = 2'd0,
      OUTCOME_ACCEPTED  = 2'd1,
      OUTCOME_BAD_CSUM  = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] seq_num;
      logic [15:0] ack_num;
      logic [15:0] flag_bits;
      logic [15:0] packet_count;
      logic [15:0] header_checksum;
   } header_type;

   typedef struct packed {
      logic [15:0] reply_ack;
      logic [6:0]  reply_flags;
      logic [15:0] reply_checksum;
      outcome_type outcome;
   } reply_type;

   // decision handed from the state unit to the result register
   typedef struct packed {
      logic      emit;
      reply_type reply;
   } decision_type;

   // fold a 17-bit sum once; a carry out of bit 15 leaves a small low half,
   // so the second add cannot carry again
   function automatic logic [15:0] fold17(input logic [16:0] value);
      logic [16:0] folded;
      folded = {1'b0, value[15:0]} + {16'd0, value[16]};
      return folded[15:0];
   endfunction

endpackage

FILE: hw/rtl/swr_csum.sv
// ----------------------------------------------------------------------------
// swr_csum - header checksum check
// Sums the ten covered halfwords, folds the sum to 16 bits and tests that the
// folded sum plus the received checksum gives all ones without wrapping.
// ----------------------------------------------------------------------------
module swr_csum
   import swr_pkg::*;
(
   input  header_type hdr,
   output logic       csum_ok
);

   logic [19:0] sum_raw;
   logic [16:0] fold_one;
   logic [16:0] fold_two;
   logic [16:0] check_sum;

   // add the ten halfwords; ten 16-bit terms fit in 20 bits
   always_comb begin
      sum_raw = {4'd0, hdr.src_addr[15:0]} + {4'd0, hdr.src_addr[31:16]}
              + {4'd0, hdr.dst_addr[15:0]} + {4'd0, hdr.dst_addr[31:16]}
              + {4'd0, hdr.src_port}       + {4'd0, hdr.dst_port}
              + {4'd0, hdr.seq_num}        + {4'd0, hdr.ack_num}
              + {4'd0, hdr.flag_bits}      + {4'd0, hdr.packet_count};
   end

   // fold twice: after the second add the value stays within 16 bits
   always_comb begin
      fold_one  = {1'b0, sum_raw[15:0]} + {13'd0, sum_raw[19:16]};
      fold_two  = {1'b0, fold_one[15:0]} + {16'd0, fold_one[16]};
      check_sum = {1'b0, fold_two[15:0]} + {1'b0, hdr.header_checksum};
      csum_ok   = (check_sum == {1'b0, HalfOnes});
   end

endmodule

FILE: hw/rtl/swr_state.sv
// ----------------------------------------------------------------------------
// swr_state - receiver state and reply decision
// Holds the last accepted sequence number, the pending acknowledgement and
// the NACK mode, classifies each header and builds its reply.
// ----------------------------------------------------------------------------
module swr_state
   import swr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  header_type   hdr,
   input  logic         csum_ok,
   output decision_type decision
);

   logic [15:0] last_seq_ff,    last_seq_in;
   logic [15:0] pending_ack_ff, pending_ack_in;
   logic        nack_mode_ff,   nack_mode_in;

   logic        in_use;
   logic        is_dup;
   logic        is_bad;
   logic        is_new;
   logic        nack_now;
   logic [15:0] rack;
   logic [15:0] dup_ack;
   logic [6:0]  rflags;
   outcome_type rcode;

   // classify the header
   always_comb begin
      in_use   = hdr.flag_bits[0];
      is_dup   = (hdr.seq_num == last_seq_ff);
      is_new   = !is_dup && csum_ok;
      is_bad   = !is_dup && !csum_ok;
      dup_ack  = (last_seq_ff == 16'd1) ? 16'd0 : 16'd1;
      nack_now = nack_mode_ff || is_bad;
   end

   // build the reply
   always_comb begin
      if (is_dup) begin
         rack  = dup_ack;
         rcode = OUTCOME_DUPLICATE;
      end else if (is_new) begin
         rack  = hdr.seq_num;
         rcode = OUTCOME_ACCEPTED;
      end else begin
         rack  = pending_ack_ff;
         rcode = OUTCOME_BAD_CSUM;
      end
      rflags = nack_now ? ReplyNackCode : ReplyAckCode;
      decision.emit                 = in_use;
      decision.reply.reply_ack      = rack;
      decision.reply.reply_flags    = rflags;
      decision.reply.reply_checksum = ~fold17({1'b0, rack} + {10'd0, rflags});
      decision.reply.outcome        = rcode;
   end

   // advance the state on each in-use header
   always_comb begin
      last_seq_in    = last_seq_ff;
      pending_ack_in = pending_ack_ff;
      nack_mode_in   = nack_mode_ff;
      if (step && in_use) begin
         if (is_dup) begin
            pending_ack_in = dup_ack;
         end else if (is_new) begin
            last_seq_in    = hdr.seq_num;
            pending_ack_in = 16'd0;
            nack_mode_in   = 1'b0;
         end else begin
            nack_mode_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff    <= 16'd0;
         pending_ack_ff <= 16'd0;
         nack_mode_ff   <= 1'b0;
      end else begin
         last_seq_ff    <= last_seq_in;
         pending_ack_ff <= pending_ack_in;
         nack_mode_ff   <= nack_mode_in;
      end
   end

   // a checksum failure always leaves NACK mode set
   assert property (@(posedge clock) disable iff (reset)
      step && in_use && is_bad |=> nack_mode_ff)
      else $error("NACK mode not set after checksum failure");

   // an accepted packet records its sequence number and starts a fresh reply
   assert property (@(posedge clock) disable iff (reset)
      step && in_use && is_new |=>
         !nack_mode_ff && (pending_ack_ff == 16'd0)
         && (last_seq_ff == $past(hdr.seq_num)))
      else $error("accept did not update state");

   // headers that are not in use leave the state alone
   assert property (@(posedge clock) disable iff (reset)
      step && !in_use |=> $stable(last_seq_ff) && $stable(pending_ack_ff)
         && $stable(nack_mode_ff))
      else $error("state changed on a header not in use");

   // a failed packet always answers with a NACK
   assert property (@(posedge clock) disable iff (reset)
      in_use && is_bad |-> (rflags == ReplyNackCode))
      else $error("checksum failure reply without NACK");

endmodule

FILE: hw/rtl/stop_and_wait_receiver.sv
// ----------------------------------------------------------------------------
// stop_and_wait_receiver - receiver half of a stop-and-wait datagram link
// One packet header per transfer in, at most one reply header per transfer out.
// ----------------------------------------------------------------------------
// Each header is taken into an input register, classified (duplicate, good new
// packet, checksum failure) by one pass of logic and its reply is loaded into
// the result register; one header per cycle is sustained while the reply side
// does not stall. Headers with the in-use bit clear are consumed and give no
// reply. The input register and result register decouple the two channels; a
// stalled reply holds the input register and then backpressures req_tready.
// The checksum adder tree and fold set the cycle length.
module stop_and_wait_receiver
   import swr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80],
   // seq_num[111:96], ack_num[127:112], flag_bits[143:128],
   // packet_count[159:144], header_checksum[175:160]
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // reply_ack[15:0], reply_flags[22:16], reply_checksum[38:23],
   // outcome[40:39], zero fill[47:41]
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic         hdr_valid_ff, hdr_valid_in;
   header_type   hdr_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   reply_type    rsp_ff;

   logic         out_free;
   logic         hdr_advance;
   logic         req_fire;
   logic         csum_ok;
   decision_type decision;
   header_type   req_hdr;

   // unpack the input transfer
   always_comb begin
      req_hdr.src_addr        = req_tdata[31:0];
      req_hdr.dst_addr        = req_tdata[63:32];
      req_hdr.src_port        = req_tdata[79:64];
      req_hdr.dst_port        = req_tdata[95:80];
      req_hdr.seq_num         = req_tdata[111:96];
      req_hdr.ack_num         = req_tdata[127:112];
      req_hdr.flag_bits       = req_tdata[143:128];
      req_hdr.packet_count    = req_tdata[159:144];
      req_hdr.header_checksum = req_tdata[175:160];
   end

   // flow control between the two registers
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      hdr_advance  = hdr_valid_ff && out_free;
      req_tready   = !hdr_valid_ff || out_free;
      req_fire     = req_tvalid && req_tready;
      hdr_valid_in = req_fire || (hdr_valid_ff && !hdr_advance);
      if (hdr_advance) begin
         rsp_valid_in = decision.emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_valid_ff <= hdr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the header and the reply payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hdr_ff <= req_hdr;
      end
      if (hdr_advance) begin
         rsp_ff <= decision.reply;
      end
   end

   swr_csum u_csum (
      .hdr     (hdr_ff),
      .csum_ok (csum_ok)
   );

   swr_state u_state (
      .clock    (clock),
      .reset    (reset),
      .step     (hdr_advance),
      .hdr      (hdr_ff),
      .csum_ok  (csum_ok),
      .decision (decision)
   );

   // pack the reply transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.outcome, rsp_ff.reply_checksum,
                        rsp_ff.reply_flags, rsp_ff.reply_ack};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the stop-and-wait receiver
// Drives packet headers on the request stream and checks every reply
// transfer against a scoreboard. The scoreboard mirrors the receiver's
// sequence, held-acknowledgement and NACK state. A short directed run comes
// first, then three random phases with shifting idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb
   import swr_pkg::*;
();

   // Mirror of the receiver: predicts one reply per in-use header.
   class reply_scoreboard;
      reply_type   expected_replies[$];
      logic [15:0] last_seq;
      logic [15:0] pending_ack;
      logic        nack_mode;
      int          errors;

      function new();
         last_seq    = '0;
         pending_ack = '0;
         nack_mode   = 1'b0;
         errors      = 0;
      endfunction

      // Add carries back into the low half until none are left.
      static function logic [15:0] fold_carry(input logic [31:0] value);
         logic [31:0] s;
         s = value;
         while (s[31:16] != 16'd0) s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
         return s[15:0];
      endfunction

      // Plain sum of the ten halfwords covered by the header checksum.
      static function logic [31:0] header_sum(input header_type h);
         return {16'd0, h.src_addr[15:0]} + {16'd0, h.src_addr[31:16]}
              + {16'd0, h.dst_addr[15:0]} + {16'd0, h.dst_addr[31:16]}
              + {16'd0, h.src_port} + {16'd0, h.dst_port} + {16'd0, h.seq_num}
              + {16'd0, h.ack_num} + {16'd0, h.flag_bits} + {16'd0, h.packet_count};
      endfunction

      // Fill in the checksum that makes the header verify.
      static function header_type sealed(input header_type h);
         header_type s;
         s = h;
         s.header_checksum = HalfOnes - fold_carry(header_sum(h));
         return s;
      endfunction

      // Note an accepted header and queue the reply it should cause.
      function void note_header(input header_type h);
         reply_type r;
         logic      fresh;
         fresh = 1'b0;
         if (!h.flag_bits[0]) return;
         if (h.seq_num == last_seq) begin
            pending_ack = (last_seq == 16'd1) ? 16'd0 : 16'd1;
            r.reply_ack = pending_ack;
            r.outcome   = OUTCOME_DUPLICATE;
         end else if ({16'd0, fold_carry(header_sum(h))} + {16'd0, h.header_checksum}
                      == {16'd0, HalfOnes}) begin
            last_seq    = h.seq_num;
            r.reply_ack = h.seq_num;
            r.outcome   = OUTCOME_ACCEPTED;
            fresh       = 1'b1;
         end else begin
            nack_mode   = 1'b1;
            r.reply_ack = pending_ack;
            r.outcome   = OUTCOME_BAD_CSUM;
         end
         r.reply_flags    = nack_mode ? ReplyNackCode : ReplyAckCode;
         r.reply_checksum = ~fold_carry({16'd0, r.reply_ack} + {25'd0, r.reply_flags});
         expected_replies.push_back(r);
         // a good new packet starts the pending reply afresh
         if (fresh) begin
            pending_ack = '0;
            nack_mode   = 1'b0;
         end
      endfunction

      // Compare a reply transfer with the oldest expectation.
      function void check_reply(input reply_type got);
         reply_type exp_r;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply %h", $time, got);
            errors++;
            return;
         end
         exp_r = expected_replies.pop_front();
         if (got.reply_ack != exp_r.reply_ack) begin
            $display("%0t: reply_ack expected %h actual %h", $time,
                     exp_r.reply_ack, got.reply_ack);
            errors++;
         end
         if (got.reply_flags != exp_r.reply_flags) begin
            $display("%0t: reply_flags expected %h actual %h", $time,
                     exp_r.reply_flags, got.reply_flags);
            errors++;
         end
         if (got.reply_checksum != exp_r.reply_checksum) begin
            $display("%0t: reply_checksum expected %h actual %h", $time,
                     exp_r.reply_checksum, got.reply_checksum);
            errors++;
         end
         if (got.outcome != exp_r.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time,
                     exp_r.outcome, got.outcome);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   int unsigned     send_idle = 0;
   int unsigned     recv_idle = 0;
   reply_scoreboard sb;

   stop_and_wait_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Give up after a generous fixed time.
   initial begin
      #400000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic logic [ReqDataWidth-1:0] pack_header(input header_type h);
      return {h.header_checksum, h.packet_count, h.flag_bits, h.ack_num, h.seq_num,
              h.dst_port, h.src_port, h.dst_addr, h.src_addr};
   endfunction

   function automatic reply_type unpack_reply(input logic [RspDataWidth-1:0] d);
      reply_type r;
      r.reply_ack      = d[15:0];
      r.reply_flags    = d[22:16];
      r.reply_checksum = d[38:23];
      r.outcome        = outcome_type'(d[40:39]);
      return r;
   endfunction

   // Random header: mostly good new packets and duplicates, some damage.
   function automatic header_type random_header();
      header_type  h;
      int unsigned kind;
      kind              = $urandom_range(99);
      h.src_addr        = $urandom;
      h.dst_addr        = $urandom;
      h.src_port        = 16'($urandom);
      h.dst_port        = 16'($urandom);
      h.seq_num         = 16'($urandom);
      h.ack_num         = 16'($urandom);
      h.flag_bits       = 16'($urandom);
      h.packet_count    = 16'($urandom);
      h.header_checksum = 16'($urandom);
      h.flag_bits[0]    = 1'b1;
      if (kind < 8) begin
         h.flag_bits[0] = 1'b0;
      end else if (kind < 25) begin
         h.seq_num = sb.last_seq;
         if ($urandom_range(1) == 1) h = reply_scoreboard::sealed(h);
      end else begin
         // small sequence numbers reach the duplicate-of-one case
         if ($urandom_range(9) == 0) h.seq_num = 16'($urandom_range(2));
         if (h.seq_num == sb.last_seq) h.seq_num[0] = ~h.seq_num[0];
         if (kind < 70) begin
            h = reply_scoreboard::sealed(h);
         end else if (kind < 85) begin
            h = reply_scoreboard::sealed(h);
            h.header_checksum = h.header_checksum + 16'($urandom_range(3, 1));
         end
      end
      return h;
   endfunction

   // Offer one header, hold it until the transfer, then note it.
   task automatic send_header(input header_type h);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_header(h);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_header(h);
   endtask

   // Hold the sender off until every queued reply has come back.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                            input int unsigned count);
      header_type  h;
      int unsigned sent;
      sent = 0;
      send_idle = s_idle;
      recv_idle <= r_idle;
      while (sent < count) begin
         h = random_header();
         send_header(h);
         if (h.flag_bits[0]) sent++;
      end
   endtask

   // Reply side: check each transfer, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_reply(unpack_reply(rsp_tdata));
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      header_type h;
      sb = new();
      send_idle = 28;
      recv_idle = 88;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // duplicate of the reset sequence number
      h = '0;
      h.flag_bits = 16'h0001;
      send_header(h);
      // in-use bit clear: ignored
      h = '1;
      h.flag_bits = 16'hfffe;
      send_header(h);
      // damaged packet: NACK carrying the held acknowledgement
      h = '0;
      h.flag_bits = 16'h0001;
      h.seq_num = 16'd5;
      h.header_checksum = 16'h1234;
      send_header(h);
      // duplicate while in NACK mode
      h = '0;
      h.flag_bits = 16'h0001;
      send_header(h);
      // good packet still answered with NACK flags, then mode clears
      h.seq_num = 16'd1;
      send_header(reply_scoreboard::sealed(h));
      // duplicate of sequence one acknowledges zero
      send_header(h);
      // all ones: folded sum is all ones, checksum zero verifies
      h = '1;
      send_header(reply_scoreboard::sealed(h));
      // negative zero checksum must not verify
      h = '1;
      h.seq_num = 16'hfffe;
      send_header(h);
      // off by one
      h = reply_scoreboard::sealed(h);
      h.header_checksum = h.header_checksum + 16'd1;
      send_header(h);
      // address halves at opposite extremes
      h.src_addr     = 32'hffff0000;
      h.dst_addr     = 32'h0000ffff;
      h.src_port     = 16'hffff;
      h.dst_port     = 16'h0000;
      h.seq_num      = 16'd2;
      h.ack_num      = 16'hffff;
      h.flag_bits    = 16'h0045;
      h.packet_count = 16'h0000;
      send_header(reply_scoreboard::sealed(h));
      send_header(h);
      h.seq_num = 16'd1;
      send_header(reply_scoreboard::sealed(h));
      send_header(h);

      run_phase(28, 88, 160);
      drain_replies();
      run_phase(88, 28, 160);
      drain_replies();
      run_phase(0, 0, 160);
      drain_replies();
      repeat (10) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
